@@ rtl/core/rainflow_cycle_counter_macros.svh @@
// ----------------------------------------------------------------------------
// Rainflow cycle counter assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef RAINFLOW_CYCLE_COUNTER_MACROS_SVH
`define RAINFLOW_CYCLE_COUNTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RFC_ASSERT_NOW(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RFC_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/rfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Rainflow cycle counter package
// Shared constants, command codes and control structs of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_RESULTS     = 64;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

    // Input command, carried on the input tuser bit.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Requests from the sequencer to the result buffer.
    typedef struct packed {
        logic put;    // new result enters the hold stage
        logic close;  // item finished, held result goes out with tlast
    } t_ob_req;

    // Result buffer status back to the sequencer.
    typedef struct packed {
        logic slot_ok;   // a put can be taken this cycle
        logic close_ok;  // a close can be taken this cycle
    } t_ob_stat;

endpackage

`default_nettype wire

@@ rtl/core/rfc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/rfc_outbuf.sv @@
// ----------------------------------------------------------------------------
// Rainflow result buffer
// Holds one result back until the next one or the end of the item is known,
// so that tlast can be set, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_outbuf #(
    parameter int SAMPLE_BITS = rfc_pkg::SAMPLE_BITS_DEF,
    localparam int RW         = SAMPLE_BITS + 1,
    localparam int MDW        = ((2 * RW + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rfc_pkg::t_ob_req     i_req,
    output rfc_pkg::t_ob_stat    o_stat,
    input  logic [RW-1:0]        i_range,
    input  logic signed [RW-1:0] i_sum,
    input  logic                 i_half,
    input  logic                 i_ovf,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [MDW-1:0]       o_data,
    output logic [1:0]           o_user,
    output logic                 o_last
);

    logic                 r_hold_v;
    logic [RW-1:0]        r_hold_rng;
    logic signed [RW-1:0] r_hold_sum;
    logic [1:0]           r_hold_user;
    logic                 r_out_v;
    logic [RW-1:0]        r_out_rng;
    logic signed [RW-1:0] r_out_sum;
    logic [1:0]           r_out_user;
    logic                 r_out_last;
    logic                 out_free;
    logic                 load_out;

    assign out_free        = !r_out_v || i_ready;
    assign o_stat.slot_ok  = !r_hold_v || out_free;
    assign o_stat.close_ok = !r_hold_v || out_free;
    // A held result moves out when a newer one arrives or the item closes.
    assign load_out        = r_hold_v && (i_req.put || i_req.close);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_req.put) begin
                r_hold_v <= 1'b1;
            end else if (i_req.close) begin
                r_hold_v <= 1'b0;
            end
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.put) begin
            r_hold_rng  <= i_range;
            r_hold_sum  <= i_sum;
            r_hold_user <= {i_ovf, i_half};
        end
        if (load_out) begin
            r_out_rng  <= r_hold_rng;
            r_out_sum  <= r_hold_sum;
            r_out_user <= r_hold_user;
            r_out_last <= i_req.close;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = MDW'({r_out_sum, r_out_rng});
    assign o_user  = r_out_user;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/core/rainflow_cycle_counter.sv @@
// ----------------------------------------------------------------------------
// Rainflow cycle counter
// Four-point rainflow counting over a turning-point stack held in a RAM.
// ----------------------------------------------------------------------------
// Input beats: s_axis_tdata carries a signed sample, s_axis_tuser is the
// command (sample or end of data). Output beats carry one counted cycle:
// range and level sum in m_axis_tdata, half-cycle and overflow flags in
// m_axis_tuser, and tlast on the final result caused by an input beat.
// The min_range register is written through i_cfg_we / i_cfg_wdata.
// One input beat is processed at a time. A sample that adds no turning
// point only passes the after and done steps. A pushed point adds a check
// when the stack then holds four or more points (three RAM reads, the
// differences and the compare), plus an emit for every closed cycle. End
// of data adds a read and an emit per stored pair for the half cycles.
// Results pass the hold stage and the output register of the result buffer.
// Reset (synchronous, active low) empties the stack, clears the flags and
// the register. A stalled receiver stops the sequencer once the result
// buffer is full; the input side then stays not ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rainflow_cycle_counter #(
    parameter int STACK_DEPTH = rfc_pkg::STACK_DEPTH_DEF,
    parameter int SAMPLE_BITS = rfc_pkg::SAMPLE_BITS_DEF,
    localparam int RW         = SAMPLE_BITS + 1,
    localparam int SDW        = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int MDW        = ((2 * RW + 7) / 8) * 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [RW-1:0]  i_cfg_wdata,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [SDW-1:0] s_axis_tdata,   // sample
    input  logic           s_axis_tuser,   // command
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [MDW-1:0] m_axis_tdata,   // cycle_range, level_sum
    output logic [1:0]     m_axis_tuser,   // is_half, overflow_seen
    output logic           m_axis_tlast
);

    localparam int W  = SAMPLE_BITS;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int NW = rfc_pkg::RES_CNT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_RDC   = 4'd4;
    localparam logic [3:0] S_DIF   = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_AFTER = 4'd7;
    localparam logic [3:0] S_FLR   = 4'd8;
    localparam logic [3:0] S_FLD   = 4'd9;
    localparam logic [3:0] S_FLN   = 4'd10;
    localparam logic [3:0] S_CLR   = 4'd11;
    localparam logic [3:0] S_EMC   = 4'd12;
    localparam logic [3:0] S_EMP   = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    localparam logic [1:0] SEEN_NONE  = 2'd0;
    localparam logic [1:0] SEEN_ONE   = 2'd1;
    localparam logic [1:0] SEEN_SLOPE = 2'd2;

    function automatic logic [RW-1:0] absdiff(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
        logic signed [RW-1:0] d;
        d = RW'(a) - RW'(b);
        return d[RW-1] ? RW'(-d) : RW'(d);
    endfunction

    // Control registers
    logic [3:0]           r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [1:0]           r_seen, n_seen;
    logic                 r_slope_up, n_slope_up;
    logic                 r_ovf, n_ovf;
    logic                 r_flush, n_flush;
    logic                 r_phase, n_phase;
    logic [NW-1:0]        r_nres, n_nres;
    logic [RW-1:0]        r_min_range;
    logic signed [W-1:0]  r_pending, n_pending;
    // Datapath registers
    logic signed [W-1:0]  r_x1, r_x2, r_x3, r_x4, n_x1, n_x2, n_x3, n_x4;
    logic [RW-1:0]        r_d21, r_d32, r_d43, n_d21, n_d32, n_d43;
    logic signed [W-1:0]  r_ea, r_eb, n_ea, n_eb, r_prev, n_prev;
    logic                 r_half, n_half;
    logic [3:0]           r_ret, n_ret;
    logic [RW-1:0]        r_rng, n_rng;
    logic signed [RW-1:0] r_sum, n_sum;
    logic [CW-1:0]        r_idx, n_idx;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic signed [W-1:0]  ram_wdata, ram_rdata;

    logic                 accept;
    logic signed [W-1:0]  feed_v;
    logic                 feed_up, feed_push;
    logic signed [W-1:0]  feed_val;
    logic                 push_req;
    logic signed [W-1:0]  push_val;

    rfc_pkg::t_ob_req     ob_req;
    rfc_pkg::t_ob_stat    ob_stat;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // End of data feeds a zero sample through the same path.
    assign feed_v    = (s_axis_tuser == rfc_pkg::CMD_SAMPLE) ? $signed(s_axis_tdata[W-1:0])
                                                             : '0;
    assign feed_up   = feed_v > r_pending;
    assign feed_push = (r_seen == SEEN_NONE) ||
                       ((feed_v != r_pending) && (r_seen == SEEN_SLOPE) &&
                        (feed_up != r_slope_up));
    assign feed_val  = (r_seen == SEEN_NONE) ? feed_v : r_pending;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_seen     = r_seen;
        n_slope_up = r_slope_up;
        n_ovf      = r_ovf;
        n_flush    = r_flush;
        n_phase    = r_phase;
        n_nres     = r_nres;
        n_pending  = r_pending;
        n_x1       = r_x1;
        n_x2       = r_x2;
        n_x3       = r_x3;
        n_x4       = r_x4;
        n_d21      = r_d21;
        n_d32      = r_d32;
        n_d43      = r_d43;
        n_ea       = r_ea;
        n_eb       = r_eb;
        n_half     = r_half;
        n_ret      = r_ret;
        n_rng      = r_rng;
        n_sum      = r_sum;
        n_idx      = r_idx;
        n_prev     = r_prev;
        ram_we     = 1'b0;
        ram_waddr  = r_cnt[AW-1:0];
        ram_wdata  = r_x4;
        ram_re     = 1'b0;
        ram_raddr  = r_idx[AW-1:0];
        push_req   = 1'b0;
        push_val   = r_pending;
        ob_req     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_flush  = (s_axis_tuser == rfc_pkg::CMD_FLUSH);
                    n_phase  = 1'b0;
                    n_nres   = '0;
                    push_req = feed_push;
                    push_val = feed_val;
                    n_state  = S_AFTER;
                    if (r_seen == SEEN_NONE) begin
                        n_pending = feed_v;
                        n_seen    = SEEN_ONE;
                    end else if (feed_v != r_pending) begin
                        n_slope_up = feed_up;
                        n_pending  = feed_v;
                        n_seen     = SEEN_SLOPE;
                    end
                end
            end
            S_CHK: begin
                if (r_cnt >= CW'(4)) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_cnt - CW'(2));
                    n_state   = S_RDA;
                end else begin
                    n_state = S_AFTER;
                end
            end
            S_RDA: begin
                n_x3      = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = AW'(r_cnt - CW'(3));
                n_state   = S_RDB;
            end
            S_RDB: begin
                n_x2      = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = AW'(r_cnt - CW'(4));
                n_state   = S_RDC;
            end
            S_RDC: begin
                n_x1    = ram_rdata;
                n_state = S_DIF;
            end
            S_DIF: begin
                n_d21   = absdiff(r_x2, r_x1);
                n_d32   = absdiff(r_x3, r_x2);
                n_d43   = absdiff(r_x4, r_x3);
                n_state = S_CMP;
            end
            S_CMP: begin
                if ((r_d32 <= r_d21) && (r_d32 <= r_d43)) begin
                    // Inner pair closes: the top point drops into its slot.
                    // Later reads stay below that slot, so no forwarding.
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_cnt - CW'(3));
                    ram_wdata = r_x4;
                    n_cnt     = r_cnt - CW'(2);
                    n_ea      = r_x2;
                    n_eb      = r_x3;
                    n_half    = 1'b0;
                    n_ret     = S_CHK;
                    n_state   = S_EMC;
                end else begin
                    n_state = S_AFTER;
                end
            end
            S_AFTER: begin
                if (!r_flush) begin
                    n_state = S_DONE;
                end else if (!r_phase) begin
                    n_phase  = 1'b1;
                    n_idx    = '0;
                    push_req = (r_seen == SEEN_SLOPE);
                    push_val = r_pending;
                    n_state  = S_FLR;
                end else begin
                    n_idx   = '0;
                    n_state = S_FLR;
                end
            end
            S_FLR: begin
                if (r_cnt < CW'(2)) begin
                    n_state = S_CLR;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                    n_state   = S_FLD;
                end
            end
            S_FLD: begin
                n_prev = ram_rdata;
                n_idx  = r_idx + CW'(1);
                if (r_idx == '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(CW'(1));
                end else begin
                    n_ea    = r_prev;
                    n_eb    = ram_rdata;
                    n_half  = 1'b1;
                    n_ret   = S_FLN;
                    n_state = S_EMC;
                end
            end
            S_FLN: begin
                if (r_idx < r_cnt) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx[AW-1:0];
                    n_state   = S_FLD;
                end else begin
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                n_cnt      = '0;
                n_pending  = '0;
                n_slope_up = 1'b0;
                n_seen     = SEEN_NONE;
                n_ovf      = 1'b0;
                n_state    = S_DONE;
            end
            S_EMC: begin
                n_rng   = absdiff(r_ea, r_eb);
                n_sum   = RW'(r_ea) + RW'(r_eb);
                n_state = S_EMP;
            end
            S_EMP: begin
                if ((r_rng < r_min_range) || (r_nres >= NW'(rfc_pkg::MAX_RESULTS))) begin
                    n_state = r_ret;
                end else if (ob_stat.slot_ok) begin
                    ob_req.put = 1'b1;
                    n_nres     = r_nres + NW'(1);
                    n_state    = r_ret;
                end
            end
            S_DONE: begin
                if (ob_stat.close_ok) begin
                    ob_req.close = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Shared stack push; a full stack drops the point and flags it.
        if (push_req) begin
            if (r_cnt < CW'(STACK_DEPTH)) begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = push_val;
                n_cnt     = r_cnt + CW'(1);
                n_x4      = push_val;
                n_state   = S_CHK;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_seen      <= SEEN_NONE;
            r_slope_up  <= 1'b0;
            r_ovf       <= 1'b0;
            r_flush     <= 1'b0;
            r_phase     <= 1'b0;
            r_nres      <= '0;
            r_pending   <= '0;
            r_min_range <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_seen     <= n_seen;
            r_slope_up <= n_slope_up;
            r_ovf      <= n_ovf;
            r_flush    <= n_flush;
            r_phase    <= n_phase;
            r_nres     <= n_nres;
            r_pending  <= n_pending;
            if (i_cfg_we) begin
                r_min_range <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1   <= n_x1;
        r_x2   <= n_x2;
        r_x3   <= n_x3;
        r_x4   <= n_x4;
        r_d21  <= n_d21;
        r_d32  <= n_d32;
        r_d43  <= n_d43;
        r_ea   <= n_ea;
        r_eb   <= n_eb;
        r_half <= n_half;
        r_ret  <= n_ret;
        r_rng  <= n_rng;
        r_sum  <= n_sum;
        r_idx  <= n_idx;
        r_prev <= n_prev;
    end

    rfc_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rfc_outbuf #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ob_req),
        .o_stat  (ob_stat),
        .i_range (r_rng),
        .i_sum   (r_sum),
        .i_half  (r_half),
        .i_ovf   (r_ovf),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/rfc_checker.sv @@
// ----------------------------------------------------------------------------
// Rainflow cycle counter checker
// Port-level assertions on the block's channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rainflow_cycle_counter_macros.svh"

module rfc_checker #(
    parameter int SAMPLE_BITS = rfc_pkg::SAMPLE_BITS_DEF,
    localparam int RW         = SAMPLE_BITS + 1,
    localparam int MDW        = ((2 * RW + 7) / 8) * 8
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           s_axis_tvalid,
    input wire logic           s_axis_tready,
    input wire logic           m_axis_tvalid,
    input wire logic           m_axis_tready,
    input wire logic [MDW-1:0] m_axis_tdata,
    input wire logic [1:0]     m_axis_tuser,
    input wire logic           m_axis_tlast
);

    // A stalled output beat keeps its content.
    `RFC_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // One input beat is in work at a time.
    `RFC_ASSERT_NEXT(a_one_item, i_clk, !i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Reset leaves no output beat pending.
    `RFC_ASSERT_NEXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !m_axis_tvalid)

    // Sum and difference of two points share their lowest bit.
    `RFC_ASSERT_NOW(a_parity, i_clk, !i_rst_n, m_axis_tvalid, m_axis_tdata[0] == m_axis_tdata[RW])

endmodule

bind rainflow_cycle_counter rfc_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_rfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Rainflow cycle counter testbench
// Streams sample and end-of-data beats into the counter under random source
// gaps and sink stalls. A behavioral four-point rainflow predictor computes
// the expected cycles, and the monitor checks every output beat against them.
// It runs over several min_range settings, including both extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = rfc_pkg::STACK_DEPTH_DEF;
    localparam int RW         = rfc_pkg::SAMPLE_BITS_DEF + 1;
    localparam int SDW        = 16;
    localparam int MDW        = 40;
    localparam int SETTLE     = 400;
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_LEN  = 60;

    typedef struct {
        logic            cmd;
        logic [SDW-1:0]  smp;
        bit              drain;
    } t_in_item;

    typedef struct {
        logic [RW-1:0] rng;
        logic [RW-1:0] lsum;
        logic          half;
        logic          ovf;
        logic          last;
    } t_cycle;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [RW-1:0]  i_cfg_wdata = '0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [SDW-1:0] s_axis_tdata = '0;   // sample
    logic           s_axis_tuser = 1'b0; // command
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [MDW-1:0] m_axis_tdata;        // cycle_range, level_sum
    logic [1:0]     m_axis_tuser;        // is_half, overflow_seen
    logic           m_axis_tlast;

    rainflow_cycle_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_in_item pending_items[$];
    t_cycle   expected_cycles[$];
    int       errors = 0;
    bit       no_gaps = 1'b0;
    bit       next_drain = 1'b0;
    int       items_queued = 0;

    // Predictor state.
    int            pt_stack[DEPTH];
    int            pt_count = 0;
    int            pend_pt = 0;
    int            slope_dir = 0;
    int            seen_state = 0;
    bit            ovf_flag = 1'b0;
    logic [RW-1:0] range_floor = '0;
    int            step_results = 0;

    function automatic int abs_diff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic emit_cycle(input int a, input int b, input bit half);
        t_cycle c;
        int     r;
        r = abs_diff(a, b);
        if (r < int'(range_floor) || step_results >= rfc_pkg::MAX_RESULTS)
            return;
        c.rng  = r[RW-1:0];
        c.lsum = RW'(a + b);
        c.half = half;
        c.ovf  = ovf_flag;
        c.last = 1'b0;
        expected_cycles.insert(expected_cycles.size(), c);
        step_results++;
    endtask

    task automatic push_turning(input int v);
        int x1, x2, x3, x4, r;
        if (pt_count >= DEPTH) begin
            ovf_flag = 1'b1;
            return;
        end
        pt_stack[pt_count] = v;
        pt_count++;
        while (pt_count >= 4) begin
            x1 = pt_stack[pt_count-4];
            x2 = pt_stack[pt_count-3];
            x3 = pt_stack[pt_count-2];
            x4 = pt_stack[pt_count-1];
            r  = abs_diff(x3, x2);
            if (r <= abs_diff(x2, x1) && r <= abs_diff(x4, x3)) begin
                emit_cycle(x2, x3, 1'b0);
                pt_stack[pt_count-3] = x4;
                pt_count -= 2;
            end else begin
                break;
            end
        end
    endtask

    task automatic feed_level(input int v);
        int d;
        if (seen_state == 0) begin
            pend_pt = v;
            seen_state = 1;
            push_turning(v);
            return;
        end
        if (v == pend_pt)
            return;
        d = (v > pend_pt) ? 1 : -1;
        if (seen_state >= 2 && d != slope_dir)
            push_turning(pend_pt);
        slope_dir = d;
        pend_pt = v;
        seen_state = 2;
    endtask

    task automatic predict_cycles(input logic cmd, input logic [SDW-1:0] smp);
        int v;
        step_results = 0;
        if (cmd == rfc_pkg::CMD_SAMPLE) begin
            v = $signed(smp);
            feed_level(v);
        end else begin
            feed_level(0);
            if (seen_state == 2)
                push_turning(pend_pt);
            for (int i = 0; i + 1 < pt_count; i++)
                emit_cycle(pt_stack[i], pt_stack[i+1], 1'b1);
            pt_count = 0;
            pend_pt = 0;
            slope_dir = 0;
            seen_state = 0;
            ovf_flag = 1'b0;
        end
        if (step_results > 0)
            expected_cycles[expected_cycles.size()-1].last = 1'b1;
    endtask

    // Source side.
    int src_gap = 0;
    t_in_item drv_item;

    // A drain item also holds back in the cycle of an accepted beat, since
    // that beat's prediction may not be in the queue yet.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         (!pending_items[0].drain ||
                          (expected_cycles.size() == 0 &&
                           !(s_axis_tvalid && s_axis_tready)))) begin
                drv_item = pending_items[0];
                pending_items.delete(0);
                s_axis_tdata  <= drv_item.smp;
                s_axis_tuser  <= drv_item.cmd;
                s_axis_tvalid <= 1'b1;
                src_gap = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side.
    int sink_stall = 0;

    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            sink_stall = pick_gap();
        end
    end

    // Prediction on accepted inputs, checking on accepted outputs.
    t_cycle want;
    t_cycle got;

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            predict_cycles(s_axis_tuser, s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.rng  = m_axis_tdata[RW-1:0];
            got.lsum = m_axis_tdata[2*RW-1:RW];
            got.half = m_axis_tuser[0];
            got.ovf  = m_axis_tuser[1];
            got.last = m_axis_tlast;
            if (expected_cycles.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected cycle beat: range %0d sum %0d half %0b ovf %0b last %0b",
                             got.rng, $signed(got.lsum), got.half, got.ovf, got.last);
            end else begin
                want = expected_cycles[0];
                expected_cycles.delete(0);
                if (got.rng !== want.rng || got.lsum !== want.lsum ||
                    got.half !== want.half || got.ovf !== want.ovf ||
                    got.last !== want.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"cycle mismatch: expected range %0d sum %0d half %0b ",
                                  "ovf %0b last %0b, got range %0d sum %0d half %0b ",
                                  "ovf %0b last %0b"},
                                 want.rng, $signed(want.lsum), want.half, want.ovf,
                                 want.last, got.rng, $signed(got.lsum), got.half,
                                 got.ovf, got.last);
                end
            end
        end
    end

    // Ends the run if no beat moves on either side for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d items and %0d cycles outstanding",
                     pending_items.size(), expected_cycles.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_item(input logic cmd, input int v);
        t_in_item it;
        it.cmd = cmd;
        it.smp = v[SDW-1:0];
        it.drain = next_drain;
        next_drain = 1'b0;
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endtask

    // Waits until the counter is drained, then lets any silent work finish.
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_cycles.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_floor(input logic [RW-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        range_floor = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic int rand_level(int scale);
        case (scale)
            0: return $urandom_range(0, 100) - 50;
            1: return $urandom_range(0, 6000) - 3000;
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    // Ordinary load history; sometimes left open so the stack carries over.
    task automatic add_wave();
        int len, scale, v, prev;
        len = $urandom_range(4, 30);
        scale = $urandom_range(0, 2);
        prev = 0;
        for (int i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(0, 99) < 15)
                v = prev;
            else
                v = rand_level(scale);
            add_item(rfc_pkg::CMD_SAMPLE, v);
            prev = v;
        end
        if ($urandom_range(0, 99) < 70)
            add_item(rfc_pkg::CMD_FLUSH, 0);
    endtask

    // Alternating points of growing amplitude never close, so the stack fills.
    task automatic add_expanding();
        int len, stride;
        len = $urandom_range(34, 40);
        stride = $urandom_range(1, 800);
        for (int k = 1; k <= len; k++)
            add_item(rfc_pkg::CMD_SAMPLE, (k % 2) ? k * stride : -k * stride);
        add_item(rfc_pkg::CMD_FLUSH, 0);
    endtask

    task automatic add_noise();
        int len;
        len = $urandom_range(3, 10);
        for (int i = 0; i < len; i++)
            add_item(($urandom_range(0, 3) == 0) ? rfc_pkg::CMD_FLUSH : rfc_pkg::CMD_SAMPLE,
                     $urandom());
    endtask

    task automatic random_phase(input logic [RW-1:0] floor_value, input bit burst);
        int pick;
        int chunk;
        write_floor(floor_value);
        no_gaps = burst;
        items_queued = 0;
        chunk = 0;
        while (items_queued < PHASE_LEN) begin
            // The second history of a phase always waits for the first one's beats.
            if (chunk == 1 || $urandom_range(0, 99) < 5)
                next_drain = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                add_wave();
            else if (pick < 80)
                add_expanding();
            else
                add_noise();
            chunk++;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_floor('0);
        // End of data with no samples, then with a single kept point.
        add_item(rfc_pkg::CMD_FLUSH, 0);
        add_item(rfc_pkg::CMD_SAMPLE, 0);
        add_item(rfc_pkg::CMD_FLUSH, 0);
        add_item(rfc_pkg::CMD_SAMPLE, 5);
        add_item(rfc_pkg::CMD_FLUSH, 0);
        // Full-scale swings with a repeated sample in between.
        add_item(rfc_pkg::CMD_SAMPLE, -32768);
        add_item(rfc_pkg::CMD_SAMPLE, 32767);
        add_item(rfc_pkg::CMD_SAMPLE, 32767);
        add_item(rfc_pkg::CMD_SAMPLE, -32768);
        add_item(rfc_pkg::CMD_SAMPLE, 32767);
        add_item(rfc_pkg::CMD_SAMPLE, -1);
        add_item(rfc_pkg::CMD_FLUSH, 0);
        // A history with nested full cycles.
        add_item(rfc_pkg::CMD_SAMPLE, 0);
        add_item(rfc_pkg::CMD_SAMPLE, 10);
        add_item(rfc_pkg::CMD_SAMPLE, 2);
        add_item(rfc_pkg::CMD_SAMPLE, 8);
        add_item(rfc_pkg::CMD_SAMPLE, 1);
        add_item(rfc_pkg::CMD_SAMPLE, 20);
        add_item(rfc_pkg::CMD_SAMPLE, -7);
        add_item(rfc_pkg::CMD_FLUSH, 0);

        // The first random history waits for every pending cycle beat.
        next_drain = 1'b1;
        random_phase('0, 1'b0);
        random_phase(17'd1, 1'b1);
        random_phase(RW'($urandom_range(2, 3000)), 1'b0);
        random_phase({RW{1'b1}}, 1'b0);
        random_phase(RW'($urandom_range(1, 200)), 1'b0);

        wait_idle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/rfc_pkg.sv
rtl/core/rfc_ram.sv
rtl/core/rfc_outbuf.sv
rtl/core/rainflow_cycle_counter.sv
rtl/core/rfc_checker.sv
test/tb_top.sv
